// ===== rtl/core/utopg_pkg.sv =====
package utopg_pkg;

    // frame layout
    localparam int DATA_BITS   = 8;
    localparam int GUARD_BITS  = 6;
    localparam int POS_W       = 5;
    localparam int BIT_TICKS_W = 16;

    localparam logic [POS_W-1:0] POS_IDLE       = POS_W'(0);
    localparam logic [POS_W-1:0] POS_START      = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DATA_LAST  = POS_W'(DATA_BITS + 1);
    localparam logic [POS_W-1:0] POS_PARITY     = POS_W'(DATA_BITS + 2);
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(DATA_BITS + 2 + GUARD_BITS);

    localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RESET = BIT_TICKS_W'(104);

    // register map (word index)
    localparam logic REG_BIT_TICKS = 1'b0;

    typedef struct packed {
        logic                 send_request;
        logic [DATA_BITS-1:0] tx_byte;
    } in_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
    } out_t;

endpackage

// ===== rtl/core/utopg_core.sv =====
module utopg_core #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  utopg_pkg::in_t                      req,
    input  logic [utopg_pkg::BIT_TICKS_W-1:0]   bit_ticks,
    output utopg_pkg::out_t                     res
);

    // compare width: holds both the bit time and 2^TICK_COUNT_WIDTH
    localparam int CW = (TICK_COUNT_WIDTH + 1 > utopg_pkg::BIT_TICKS_W + 1) ?
                        TICK_COUNT_WIDTH + 1 : utopg_pkg::BIT_TICKS_W + 1;

    logic [utopg_pkg::POS_W-1:0]     pos_reg,   pos_next;
    logic [TICK_COUNT_WIDTH-1:0]     tick_reg,  tick_next;
    logic [utopg_pkg::DATA_BITS-1:0] shift_reg, shift_next;
    logic                            par_reg,   par_next;
    logic                            line_reg,  line_next;
    logic                            acc;

    logic [CW-1:0] bt_ext;
    logic [CW-1:0] limit;
    logic [CW-1:0] eff;
    logic [CW-1:0] nxt;
    logic          bit_done;

    assign bt_ext   = CW'(bit_ticks);
    assign limit    = CW'(1) << TICK_COUNT_WIDTH;
    assign eff      = (bt_ext == '0) ? CW'(1) : ((bt_ext > limit) ? limit : bt_ext);
    assign nxt      = CW'(tick_reg) + CW'(1);
    assign bit_done = (nxt >= eff);

    always_comb begin
        pos_next   = pos_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        par_next   = par_reg;
        line_next  = line_reg;
        acc        = 1'b0;

        // advance the frame in progress
        if (pos_reg != utopg_pkg::POS_IDLE) begin
            if (bit_done) begin
                tick_next = '0;
                if (pos_reg >= utopg_pkg::POS_LAST) begin
                    pos_next  = utopg_pkg::POS_IDLE;
                    line_next = 1'b1;
                end else begin
                    pos_next = pos_reg + utopg_pkg::POS_W'(1);
                    if (pos_next >= utopg_pkg::POS_DATA_FIRST &&
                        pos_next <= utopg_pkg::POS_DATA_LAST) begin
                        line_next  = shift_reg[0];
                        par_next   = par_reg ^ shift_reg[0];
                        shift_next = shift_reg >> 1;
                    end else if (pos_next == utopg_pkg::POS_PARITY) begin
                        line_next = par_reg;
                    end else begin
                        line_next = 1'b1;
                    end
                end
            end else begin
                tick_next = nxt[TICK_COUNT_WIDTH-1:0];
            end
        end

        // start a new frame when idle (also on the tick the guard gap ends)
        if (pos_next == utopg_pkg::POS_IDLE && req.send_request) begin
            acc        = 1'b1;
            shift_next = req.tx_byte;
            par_next   = 1'b1;
            tick_next  = '0;
            pos_next   = utopg_pkg::POS_START;
            line_next  = 1'b0;
        end
    end

    assign res.line_level = line_next;
    assign res.busy_res   = (pos_next != utopg_pkg::POS_IDLE);
    assign res.accepted   = acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= utopg_pkg::POS_IDLE;
            tick_reg  <= '0;
            shift_reg <= '0;
            par_reg   <= 1'b1;
            line_reg  <= 1'b1;
        end else if (accept) begin
            pos_reg   <= pos_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            par_reg   <= par_next;
            line_reg  <= line_next;
        end
    end

endmodule

// ===== rtl/core/utopg_obuf.sv =====
module utopg_obuf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  utopg_pkg::out_t push_data,
    output logic            full,
    output logic            m_valid,
    input  logic            m_ready,
    output utopg_pkg::out_t m_data
);

    // two-entry output buffer, head is presented
    logic [1:0]      count_reg, count_next;
    utopg_pkg::out_t head_reg,  head_next;
    utopg_pkg::out_t tail_reg,  tail_next;
    logic            pop;

    assign pop     = m_valid && m_ready;
    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = head_reg;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        case ({push, pop})
            2'b11: begin
                if (count_reg == 2'd1) begin
                    head_next = push_data;
                end else begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            2'b10: begin
                count_next = count_reg + 2'd1;
                if (count_reg == 2'd0) begin
                    head_next = push_data;
                end else begin
                    tail_next = push_data;
                end
            end
            2'b01: begin
                count_next = count_reg - 2'd1;
                head_next  = tail_reg;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ===== rtl/core/uart_tx_odd_parity_guard.sv =====
// channel   | ports                          | payload
// ----------+--------------------------------+-------------------------------------
// request   | s_valid / s_ready / s_data     | send_request, tx_byte (one tick each)
// result    | m_valid / m_ready / m_data     | line_level, busy_res, accepted
// config    | psel penable pwrite paddr ...  | bit_ticks at byte address 0
//
// one request per clock while the buffer has room: the frame state advances in
// the cycle a request is taken; its result enters a two-entry buffer at that edge
// s_ready depends only on the buffer fill, so a stalled consumer lets two results
// queue before requests are held off
// synchronous active-low reset: line idle high, frame idle, bit_ticks back to 104
module uart_tx_odd_parity_guard #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    // request channel
    input  logic            s_valid,
    output logic            s_ready,
    input  utopg_pkg::in_t  s_data,
    // result channel
    output logic            m_valid,
    input  logic            m_ready,
    output utopg_pkg::out_t m_data,
    // configuration port
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [utopg_pkg::BIT_TICKS_W-1:0] bit_ticks_reg;
    logic                              cfg_wr;
    logic                              accept;
    logic                              buf_full;
    utopg_pkg::out_t                   res;

    // apb: no wait states, word index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == utopg_pkg::REG_BIT_TICKS);
    assign prdata = (paddr[2] == utopg_pkg::REG_BIT_TICKS) ?
                    32'(bit_ticks_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg <= utopg_pkg::BIT_TICKS_RESET;
        end else if (cfg_wr) begin
            bit_ticks_reg <= pwdata[utopg_pkg::BIT_TICKS_W-1:0];
        end
    end

    // request taken whenever the output buffer has room
    assign s_ready = !buf_full;
    assign accept  = s_valid && s_ready;

    // frame sequencer: bit position, tick counter, shifter, parity
    utopg_core #(
        .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .req       (s_data),
        .bit_ticks (bit_ticks_reg),
        .res       (res)
    );

    // result buffer decouples the consumer from the tick stream
    utopg_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (res),
        .full      (buf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/core/utopg_checker.sv =====
module utopg_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input utopg_pkg::in_t  s_data,
    input logic            m_valid,
    input logic            m_ready,
    input utopg_pkg::out_t m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a taken request starts with the start bit
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |-> m_data.busy_res && !m_data.line_level)
        else $error("accepted request without low start bit");

    // idle line is high
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.busy_res |-> m_data.line_level)
        else $error("line low while idle");

    // empty buffer never blocks requests
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request blocked with empty output");

endmodule

bind uart_tx_odd_parity_guard utopg_checker u_chk (.*);

// ===== sim/tb_uart_tx_odd_parity_guard.sv =====
`timescale 1ns / 100ps

// tick-by-tick model of the transmitter plus the queue of line outputs it predicts
class tx_frame_scoreboard;
    logic [15:0] bit_ticks;
    logic [4:0]  bit_pos;
    logic [15:0] tick_cnt;
    logic [7:0]  shift_data;
    logic        parity_acc;
    logic        line_reg;

    utopg_pkg::out_t line_outputs_q[$];

    int unsigned ticks_taken;
    int unsigned frames_started;
    int unsigned results_checked;
    int unsigned mismatches;

    function new();
        bit_ticks       = utopg_pkg::BIT_TICKS_RESET;
        bit_pos         = utopg_pkg::POS_IDLE;
        tick_cnt        = '0;
        shift_data      = '0;
        parity_acc      = 1'b1;
        line_reg        = 1'b1;
        ticks_taken     = 0;
        frames_started  = 0;
        results_checked = 0;
        mismatches      = 0;
    endfunction

    function void set_bit_ticks(logic [15:0] value);
        bit_ticks = value;
    endfunction

    function bit frame_idle();
        return bit_pos == utopg_pkg::POS_IDLE;
    endfunction

    function int pending();
        return line_outputs_q.size();
    endfunction

    function void flag_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s expected %0h got %0h", what, want, got);
    endfunction

    // one accepted tick: advance the frame and note the line state it leaves
    function void advance_tick(utopg_pkg::in_t req);
        utopg_pkg::out_t want;
        logic [16:0]     eff_ticks;
        logic            took;
        took      = 1'b0;
        eff_ticks = (bit_ticks == 16'd0) ? 17'd1 : {1'b0, bit_ticks};
        ticks_taken++;
        if (bit_pos != utopg_pkg::POS_IDLE) begin
            if ({1'b0, tick_cnt} + 17'd1 >= eff_ticks) begin
                tick_cnt = '0;
                if (bit_pos >= utopg_pkg::POS_LAST) begin
                    bit_pos  = utopg_pkg::POS_IDLE;
                    line_reg = 1'b1;
                end else begin
                    bit_pos = bit_pos + 5'd1;
                    if (bit_pos >= utopg_pkg::POS_DATA_FIRST &&
                        bit_pos <= utopg_pkg::POS_DATA_LAST) begin
                        line_reg   = shift_data[0];
                        parity_acc = parity_acc ^ shift_data[0];
                        shift_data = shift_data >> 1;
                    end else if (bit_pos == utopg_pkg::POS_PARITY) begin
                        line_reg = parity_acc;
                    end else begin
                        line_reg = 1'b1;
                    end
                end
            end else begin
                tick_cnt = tick_cnt + 16'd1;
            end
        end
        if (bit_pos == utopg_pkg::POS_IDLE && req.send_request) begin
            took       = 1'b1;
            shift_data = req.tx_byte;
            parity_acc = 1'b1;
            tick_cnt   = '0;
            bit_pos    = utopg_pkg::POS_START;
            line_reg   = 1'b0;
            frames_started++;
        end
        want.line_level = line_reg;
        want.busy_res   = (bit_pos != utopg_pkg::POS_IDLE);
        want.accepted   = took;
        line_outputs_q.push_back(want);
    endfunction

    function void check_line_output(utopg_pkg::out_t got);
        utopg_pkg::out_t want;
        if (line_outputs_q.size() == 0) begin
            flag_mismatch("result with nothing outstanding", 0, got);
            return;
        end
        want = line_outputs_q.pop_front();
        results_checked++;
        if (got.line_level !== want.line_level)
            flag_mismatch($sformatf("line_level at tick %0d", results_checked),
                          want.line_level, got.line_level);
        if (got.busy_res !== want.busy_res)
            flag_mismatch($sformatf("busy_res at tick %0d", results_checked),
                          want.busy_res, got.busy_res);
        if (got.accepted !== want.accepted)
            flag_mismatch($sformatf("accepted at tick %0d", results_checked),
                          want.accepted, got.accepted);
    endfunction
endclass

module tb_uart_tx_odd_parity_guard;

    // bit_ticks sits at word 0 of the register map
    localparam logic [2:0] BIT_TICKS_ADDR = {utopg_pkg::REG_BIT_TICKS, 2'b00};
    // about 1200 ticks in all, with both sides stalling
    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    utopg_pkg::in_t  s_data;
    logic            m_valid;
    logic            m_ready;
    utopg_pkg::out_t m_data;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [2:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    tx_frame_scoreboard board;
    int unsigned        cycle_count;
    bit                 send_gaps_on;
    bit                 take_gaps_on;
    logic [15:0]        mid_bit_ticks;

    uart_tx_odd_parity_guard DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one tick request: optional idle gap, then hold valid until taken
    task automatic send_tick(input logic request, input logic [7:0] value);
        int             gap;
        utopg_pkg::in_t item;
        if ($urandom_range(0, 47) == 0)
            send_gaps_on = !send_gaps_on;
        gap               = send_gaps_on ? $urandom_range(0, 13) : 0;
        item.send_request = request;
        item.tx_byte      = value;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        board.advance_tick(item);
    endtask

    // drop valid after the last accepted request and wait for its results
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic check_bit_ticks_readback(input logic [15:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= BIT_TICKS_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {16'd0, want})
            board.flag_mismatch("bit_ticks readback", want, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // drain the results in flight, then reprogram the bit time
    // (a frame in progress carries on at the new bit time)
    task automatic program_bit_ticks(input logic [15:0] value);
        quiesce();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BIT_TICKS_ADDR;
        pwdata  <= {16'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_bit_ticks(value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_bit_ticks_readback(value);
    endtask

    // random ticks at one bit time; request density picked per phase, now and then re-picked
    task automatic run_random_phase(input logic [15:0] value, input int count);
        int density;
        program_bit_ticks(value);
        case ($urandom_range(0, 2))
            0:       density = 10;
            1:       density = 50;
            default: density = 90;
        endcase
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0)
                density = $urandom_range(5, 95);
            send_tick($urandom_range(0, 99) < density, 8'($urandom_range(0, 255)));
        end
    endtask

    // result side: random back-pressure, every result checked in order
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 47) == 0)
                take_gaps_on = !take_gaps_on;
            gap = take_gaps_on ? $urandom_range(0, 13) : 0;
            repeat (gap) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_line_output(m_data);
        end
    end

    initial begin
        // every input known from time zero, reset held low at the start
        board        = new();
        cycle_count  = 0;
        send_gaps_on = 1'b1;
        take_gaps_on = 1'b1;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset value of the bit time, then a request ignored while busy
        check_bit_ticks_readback(utopg_pkg::BIT_TICKS_RESET);
        send_tick(1'b1, 8'hA5);
        send_tick(1'b1, 8'h5A);
        send_tick(1'b0, 8'hFF);

        // shortest bit time: the frame in flight moves one bit per tick while a
        // request is held every tick, so each next frame starts on the very tick
        // the guard gap ends (all-zero byte, then all-ones byte)
        program_bit_ticks(16'd1);
        repeat (16) send_tick(1'b1, 8'h00);
        repeat (16) send_tick(1'b1, 8'hFF);

        // zero bit time behaves as one tick per bit
        program_bit_ticks(16'd0);
        send_tick(1'b1, 8'h01);
        send_tick(1'b1, 8'h80);

        // random part over a spread of bit times
        mid_bit_ticks = 16'($urandom_range(4, 20));
        run_random_phase(16'd1, 300);
        run_random_phase(16'd0, 150);
        run_random_phase(16'd2, 200);
        run_random_phase(16'd3, 150);
        run_random_phase(16'd7, 150);
        run_random_phase(mid_bit_ticks, 100);
        run_random_phase(utopg_pkg::BIT_TICKS_RESET, 60);
        // longest bit time: the current bit simply holds for the rest of the run
        run_random_phase(16'd65535, 40);

        quiesce();
        repeat (8) @(posedge aclk);

        $display("checked %0d tick results, %0d frames started", board.results_checked,
                 board.frames_started);
        $display("bit times used: 104, 1, 0, 2, 3, 7, %0d, 104 and 65535", mid_bit_ticks);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
